// ===== hw/rtl/psh_pkg.sv =====
// ----------------------------------------------------------------------------
// psh_pkg: shared definitions for the polynomial string hash
// Widths, hash constants, control types and the constant-modulus reduction.
// ----------------------------------------------------------------------------
package psh_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned HashW = 30;
	localparam int unsigned PowW  = 30;
	localparam int unsigned SumW  = 31;
	localparam int unsigned TermW = 9;
	localparam int unsigned ProdW = 40;
	localparam int unsigned MagW  = 38;

	localparam logic [HashW-1:0]        HashMod    = 30'd1000000009;
	localparam logic [5:0]              HashBase   = 6'd53;
	localparam logic signed [TermW-1:0] TermOffset = 9'sd96;
	// floor(2^40 / HashMod), rounded down so the quotient estimate never overshoots
	localparam logic [10:0]             RecipK     = 11'd1099;

	typedef struct packed {
		logic step;   // advance power by one base step
		logic clear;  // return power to one
	} power_ctl_t;

	// Reduce x (below 2^38) modulo HashMod: estimate the quotient from the top
	// bits, subtract, then one conditional correction.
	function automatic logic [HashW-1:0] mod_reduce(input logic [MagW-1:0] x);
		logic [17:0]     t;
		logic [28:0]     tk;
		logic [8:0]      q;
		logic [38:0]     qm;
		logic [MagW-1:0] diff;
		logic [30:0]     r;
		t    = x[37:20];
		tk   = 29'(t) * 29'(RecipK);
		q    = tk[28:20];
		qm   = 39'(q) * 39'(HashMod);
		diff = x - qm[MagW-1:0];
		r    = diff[30:0];
		if (r >= {1'b0, HashMod}) begin
			r = r - {1'b0, HashMod};
		end
		return r[HashW-1:0];
	endfunction

	// Signed-char byte minus 96; a zero byte gives no term.
	function automatic logic signed [TermW-1:0] term_of(input logic [ByteW-1:0] b);
		logic signed [TermW-1:0] c;
		c = signed'({b[ByteW-1], b});
		if (b == '0) begin
			return '0;
		end
		return c - TermOffset;
	endfunction

endpackage

// ===== hw/rtl/psh_if.sv =====
// ----------------------------------------------------------------------------
// psh_if: stream channels of the polynomial string hash
// Byte channel into the block and hash channel out of it, valid/ready each.
// ----------------------------------------------------------------------------
interface psh_char_if import psh_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] char_byte;
	logic             last_char;

	modport source (output valid, output char_byte, output last_char, input ready);
	modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

interface psh_hash_if import psh_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [HashW-1:0] hash_result;

	modport source (output valid, output hash_result, input ready);
	modport sink   (input valid, input hash_result, output ready);
endinterface

// ===== hw/rtl/psh_power_gen.sv =====
// ----------------------------------------------------------------------------
// psh_power_gen: running power of the hash base
// Holds 53^k mod 1000000009, stepping once per hashed byte.
// ----------------------------------------------------------------------------
module psh_power_gen import psh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  power_ctl_t       ctl,
	output logic [PowW-1:0]  power
);

	logic [PowW-1:0] power_q;
	logic [35:0]     scaled;
	logic [PowW-1:0] power_next;

	// Multiply by the base and fold back under the modulus
	always_comb begin
		scaled     = 36'(power_q) * 36'(HashBase);
		power_next = mod_reduce(MagW'(scaled));
	end

	// Clear at end of string, advance on a hashed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q <= PowW'(1);
		end else if (ctl.clear) begin
			power_q <= PowW'(1);
		end else if (ctl.step) begin
			power_q <= power_next;
		end
	end

	assign power = power_q;

endmodule

// ===== hw/rtl/polynomial_string_hash_core.sv =====
// ----------------------------------------------------------------------------
// polynomial_string_hash_core: base-53 polynomial string hash, mod 1000000009
// Byte-stream hash with truncated remainder and absolute-value result.
// ----------------------------------------------------------------------------
// The block takes one string byte per cycle and, on the byte flagged last,
// delivers the hash through stage one, stage two and its output register,
// then starts the next string from a clean state with no gap. Zero bytes
// are not hashed. The cycle is set by two register feedback loops: the
// power update (multiply by 53 and constant reduction) and the running-sum
// add with one sign-aware correction; the term product and its reduction sit
// in pipeline stages between them. While a result waits to be transferred,
// bytes keep flowing until the next last byte reaches stage two; that byte
// and one byte behind it are held and the input stalls.
module polynomial_string_hash_core import psh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	psh_char_if.sink    chars,
	psh_hash_if.source  hashes
);

	logic                    accept;
	power_ctl_t              power_ctl;
	logic [PowW-1:0]         power;
	logic signed [TermW-1:0] term;
	logic signed [ProdW-1:0] prod_c;

	logic                    v_s1, last_s1;
	logic signed [ProdW-1:0] prod_s1;
	logic [ProdW-1:0]        mag_full;
	logic [MagW-1:0]         mag;
	logic                    big_c;
	logic [HashW-1:0]        red_c;

	logic                    v_s2, last_s2, neg_s2, big_s2;
	logic [HashW-1:0]        red_s2;

	logic signed [SumW-1:0]  sum_q;
	logic signed [31:0]      part, acc, mod32;
	logic signed [SumW-1:0]  sum_next;
	logic [SumW-1:0]         sum_neg;
	logic [HashW-1:0]        sum_abs;

	logic                    outv_q;
	logic [HashW-1:0]        hash_q;
	logic                    out_free, adv2, en2, en1;

	// Flow control: each stage loads when it is empty or moving on
	assign out_free     = !outv_q || hashes.ready;
	assign adv2         = v_s2 && (!last_s2 || out_free);
	assign en2          = !v_s2 || adv2;
	assign en1          = !v_s1 || en2;
	assign chars.ready  = en1;
	assign accept       = chars.valid && en1;

	// Power sequence advances at the input transfer
	assign power_ctl.step  = accept && (chars.char_byte != '0);
	assign power_ctl.clear = accept && chars.last_char;

	psh_power_gen u_power (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (power_ctl),
		.power  (power)
	);

	// Term times current power
	assign term   = term_of(chars.char_byte);
	assign prod_c = ProdW'(term) * ProdW'($signed({1'b0, power}));

	// Stage 1: split the product into sign, magnitude class and residue
	assign mag_full = prod_s1[ProdW-1] ? ProdW'(-prod_s1) : ProdW'(prod_s1);
	assign mag      = mag_full[MagW-1:0];
	assign big_c    = mag >= MagW'(HashMod);
	assign red_c    = mod_reduce(mag);

	// Stage 2: add the residue and correct toward the sign of the exact sum
	assign mod32 = signed'(32'(HashMod));
	always_comb begin
		part = neg_s2 ? -signed'({2'b00, red_s2}) : signed'({2'b00, red_s2});
		acc  = 32'(sum_q) + part;
		if (!big_s2) begin
			if (acc >= mod32) begin
				acc = acc - mod32;
			end else if (acc <= -mod32) begin
				acc = acc + mod32;
			end
		end else if (!neg_s2) begin
			if (acc < 0) begin
				acc = acc + mod32;
			end else if (acc >= mod32) begin
				acc = acc - mod32;
			end
		end else begin
			if (acc > 0) begin
				acc = acc - mod32;
			end else if (acc <= -mod32) begin
				acc = acc + mod32;
			end
		end
		sum_next = acc[SumW-1:0];
		sum_neg  = SumW'(-sum_next);
		sum_abs  = sum_next[SumW-1] ? sum_neg[HashW-1:0] : sum_next[HashW-1:0];
	end

	// Control state: stage valids, running sum, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			sum_q  <= '0;
			outv_q <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= accept;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (adv2) begin
				sum_q <= last_s2 ? '0 : sum_next;
			end
			if (adv2 && last_s2) begin
				outv_q <= 1'b1;
			end else if (hashes.ready) begin
				outv_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1 <= prod_c;
			last_s1 <= chars.last_char;
		end
		if (en2 && v_s1) begin
			red_s2  <= red_c;
			neg_s2  <= prod_s1[ProdW-1];
			big_s2  <= big_c;
			last_s2 <= last_s1;
		end
		if (adv2 && last_s2) begin
			hash_q <= sum_abs;
		end
	end

	assign hashes.valid       = outv_q;
	assign hashes.hash_result = hash_q;

endmodule

// ===== hw/rtl/psh_checker.sv =====
// ----------------------------------------------------------------------------
// psh_checker: port-level checks for the polynomial string hash
// Watches both channels of the top level and flags broken behavior.
// ----------------------------------------------------------------------------
module psh_checker import psh_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             in_last,
	input logic             out_valid,
	input logic             out_ready,
	input logic [HashW-1:0] out_hash
);

	logic [1:0] pending_q;
	logic       last_xfer, out_xfer;

	assign last_xfer = in_valid && in_ready && in_last;
	assign out_xfer  = out_valid && out_ready;

	// Count strings closed at the input but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (last_xfer && !out_xfer) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_xfer && !last_xfer) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	// Hold a stalled result
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_hash))
		else $error("result changed while stalled");

	// A hash is always a reduced magnitude
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_hash < HashMod)
		else $error("hash out of range");

	// No result without a closed string behind it
	a_owed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result without a last byte");

endmodule

bind polynomial_string_hash_core psh_checker u_psh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (chars.valid),
	.in_ready  (chars.ready),
	.in_last   (chars.last_char),
	.out_valid (hashes.valid),
	.out_ready (hashes.ready),
	.out_hash  (hashes.hash_result)
);

// ===== dv/polynomial_string_hash_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_string_hash_core_test: self-checking bench for the string hash
// Feeds byte strings through the char channel, predicts each hash with a
// base-53 truncated-remainder model kept in the bench, and compares every
// hash transfer in order. Both channels idle at random, and the hash side
// holds off once for a long stretch so the block stalls its input.
// ----------------------------------------------------------------------------
module polynomial_string_hash_core_test;
	import psh_pkg::*;

	localparam longint PrimeMod   = 1000000009;
	localparam longint Radix      = 53;
	localparam longint CharBias   = 96;
	localparam int     RandomItems = 1500;
	localparam int     CycleLimit  = 1000000;
	localparam int     HoldOffLen  = 400;
	localparam int     DrainCycles = 10;

	typedef struct {
		logic [ByteW-1:0] char_byte;
		logic             last_char;
		bit               known;
		logic [HashW-1:0] hash;
	} char_row_t;

	// Single-byte strings and zero handling have hashes readable at a glance;
	// the longer runs wrap the power and are left to the predictor.
	char_row_t directed_rows [24] = '{
		'{8'h00, 1'b1, 1'b1, 30'd0},    // empty string
		'{8'h61, 1'b1, 1'b1, 30'd1},
		'{8'h60, 1'b1, 1'b1, 30'd0},
		'{8'h7F, 1'b1, 1'b1, 30'd31},
		'{8'h80, 1'b1, 1'b1, 30'd224},
		'{8'hFF, 1'b1, 1'b1, 30'd97},
		'{8'h01, 1'b1, 1'b1, 30'd95},
		'{8'h00, 1'b0, 1'b0, 30'd0},    // zero bytes around one char
		'{8'h61, 1'b0, 1'b0, 30'd0},
		'{8'h00, 1'b1, 1'b1, 30'd1},
		'{8'h80, 1'b0, 1'b0, 30'd0},    // most negative term, power wraps
		'{8'h80, 1'b0, 1'b0, 30'd0},
		'{8'h80, 1'b0, 1'b0, 30'd0},
		'{8'h80, 1'b0, 1'b0, 30'd0},
		'{8'h80, 1'b0, 1'b0, 30'd0},
		'{8'h80, 1'b0, 1'b0, 30'd0},
		'{8'h80, 1'b1, 1'b0, 30'd0},
		'{8'h7F, 1'b0, 1'b0, 30'd0},    // most positive term, power wraps
		'{8'h7F, 1'b0, 1'b0, 30'd0},
		'{8'h7F, 1'b0, 1'b0, 30'd0},
		'{8'h7F, 1'b0, 1'b0, 30'd0},
		'{8'h7F, 1'b0, 1'b0, 30'd0},
		'{8'h7F, 1'b0, 1'b0, 30'd0},
		'{8'h7F, 1'b1, 1'b0, 30'd0}
	};

	logic clk;
	logic arst_n;

	psh_char_if chars_ch ();
	psh_hash_if hashes_ch ();

	polynomial_string_hash_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_ch),
		.hashes (hashes_ch)
	);

	// Predictor state: signed running sum and power of the base
	longint                hash_sum;
	longint                hash_pow;
	logic [HashW-1:0]      pending_hashes [$];
	int                    mismatches = 0;
	int                    hashes_seen = 0;
	int                    cycle_count = 0;
	int                    send_calm;
	int                    recv_calm = 0;
	bit                    hold_off_done = 1'b0;

	initial begin
		clk = 1'b0;
	end

	always #4 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Advance the hash by one byte; return 1 with the hash when the string ends
	function automatic bit advance_hash(input logic [ByteW-1:0] b, input logic fin,
			output logic [HashW-1:0] h);
		longint c;
		longint mag;
		h = '0;
		if (b != '0) begin
			c = longint'(b);
			if (c >= 128) begin
				c = c - 256;
			end
			hash_sum = (hash_sum + (c - CharBias) * hash_pow) % PrimeMod;
			hash_pow = (hash_pow * Radix) % PrimeMod;
		end
		if (fin) begin
			mag = (hash_sum < 0) ? -hash_sum : hash_sum;
			h = mag[HashW-1:0];
			hash_sum = 0;
			hash_pow = 1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Mostly no gap, some short, a few long, with occasional calm stretches
	function automatic int pick_gap(inout int calm_left);
		int roll;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		roll = $urandom_range(99);
		if (roll < 4) begin
			calm_left = $urandom_range(100, 30);
			return 0;
		end
		if (roll < 60) return 0;
		if (roll < 90) return $urandom_range(3, 1);
		if (roll < 98) return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// Zero bytes, lowercase text and the full byte range
	function automatic logic [ByteW-1:0] pick_char();
		int roll;
		roll = $urandom_range(99);
		if (roll < 12) return '0;
		if (roll < 45) return ByteW'($urandom_range(8'h7A, 8'h61));
		return ByteW'($urandom_range(255, 1));
	endfunction

	// Offer one byte after a random gap, hold it until the transfer, then predict
	task automatic send_char(input logic [ByteW-1:0] b, input logic fin, input bit known,
			input logic [HashW-1:0] typed);
		int               gap;
		logic [HashW-1:0] predicted;
		gap = pick_gap(send_calm);
		if (gap > 0) begin
			chars_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_ch.valid     <= 1'b1;
		chars_ch.char_byte <= b;
		chars_ch.last_char <= fin;
		@(posedge clk);
		while (!chars_ch.ready) @(posedge clk);
		if (advance_hash(b, fin, predicted)) begin
			pending_hashes.push_back(known ? typed : predicted);
		end
	endtask

	// Byte side: reset, directed table, random strings, then drain
	initial begin
		int               sent;
		int               len;
		logic [ByteW-1:0] b;
		arst_n             <= 1'b0;
		chars_ch.valid     <= 1'b0;
		chars_ch.char_byte <= '0;
		chars_ch.last_char <= 1'b0;
		hash_sum    = 0;
		hash_pow    = 1;
		send_calm   = 0;
		sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_char(directed_rows[i].char_byte, directed_rows[i].last_char,
				directed_rows[i].known, directed_rows[i].hash);
		end

		while (sent < RandomItems) begin
			len = ($urandom_range(99) < 85) ? $urandom_range(24, 1) : $urandom_range(80, 25);
			for (int i = 0; i < len; i++) begin
				b = pick_char();
				send_char(b, i == len - 1, 1'b0, '0);
				sent++;
			end
		end
		chars_ch.valid <= 1'b0;

		while (pending_hashes.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Hash side: random stalls, one long hold-off, check each transfer in order
	initial begin
		int               gap;
		logic [HashW-1:0] want;
		hashes_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = pick_gap(recv_calm);
			if (!hold_off_done && hashes_seen >= 30) begin
				gap = HoldOffLen;
				hold_off_done = 1'b1;
			end
			if (gap > 0) begin
				hashes_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			hashes_ch.ready <= 1'b1;
			@(posedge clk);
			while (!hashes_ch.valid) @(posedge clk);
			hashes_seen++;
			if (pending_hashes.size() == 0) begin
				$display("%0t: unexpected hash transfer, actual %0d", $time,
					hashes_ch.hash_result);
				mismatches++;
			end else begin
				want = pending_hashes.pop_front();
				if (hashes_ch.hash_result !== want) begin
					$display("%0t: hash_result mismatch, expected %0d actual %0d", $time,
						want, hashes_ch.hash_result);
					mismatches++;
				end
			end
		end
	end

endmodule

// ===== files.f =====
hw/rtl/psh_pkg.sv
hw/rtl/psh_if.sv
hw/rtl/psh_power_gen.sv
hw/rtl/polynomial_string_hash_core.sv
hw/rtl/psh_checker.sv
dv/polynomial_string_hash_core_test.sv
